@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define DCBPM_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define DCBPM_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/dcbpm_pkg.sv @@
// ---------------------------------------------------------------------------
// dcbpm_pkg
// Types and constants of the blame parity matrix.
// ---------------------------------------------------------------------------
package dcbpm_pkg;

	localparam int MAX_USERS   = 8;
	localparam int MAX_SERVERS = 8;
	localparam int IDX_W       = 3;
	localparam int CNT_W       = 4;
	localparam int VEC_W       = 8;
	localparam int SLOT_W      = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(8);

	typedef enum logic [0:0] {
		CFG_USERS   = 1'b0,
		CFG_SERVERS = 1'b1
	} cfg_idx_e;

	typedef enum logic [2:0] {
		MODE_USER_ROW    = 3'd0,
		MODE_SERVER_COL  = 3'd1,
		MODE_USER_OUT    = 3'd2,
		MODE_SERVER_OUT  = 3'd3,
		MODE_BAD_USERS   = 3'd4,
		MODE_BAD_SERVERS = 3'd5,
		MODE_CONFLICTS   = 3'd6
	} mode_e;

	typedef enum logic [1:0] {
		KIND_USER_MASK   = 2'd0,
		KIND_SERVER_MASK = 2'd1,
		KIND_CONFLICT    = 2'd2,
		KIND_NONE        = 2'd3
	} kind_e;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAR   = 5'b00010,
		ST_MASK  = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_e;

	typedef struct packed {
		kind_e             kind;
		logic [VEC_W-1:0]  bad_mask;
		logic [SLOT_W-1:0] conflict_slot;
		logic [IDX_W-1:0]  user_index;
		logic [IDX_W-1:0]  server_index;
		logic              user_claim;
		logic              server_claim;
		logic              last;
	} result_t;

	// counts above the matrix size saturate
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
		clamp_count = (n > CNT_MAX) ? CNT_MAX : n;
	endfunction

	// bit i set for every position i below n
	function automatic logic [VEC_W-1:0] count_mask(input logic [CNT_W-1:0] n);
		logic [VEC_W-1:0] m;
		m = '0;
		for (int i = 0; i < VEC_W; i++) begin
			m[i] = (CNT_W'(i) < n);
		end
		count_mask = m;
	endfunction

endpackage

@@ src/dc_net_blame_parity_matrix_top.sv @@
// ---------------------------------------------------------------------------
// dc_net_blame_parity_matrix_top
// Users-by-servers claim matrix with parity and conflict queries.
// ---------------------------------------------------------------------------
// Loads (row, column, output bit) are taken in idle and give no result.
// Bad-user and bad-server queries walk all eight rows or columns through one
// parity unit, one per cycle, then emit the mask result when the output
// register is free. A conflict query visits one cell per cycle unless it
// stalls; a conflict is held back until the next one is found so that the
// last one can carry last = 1, and the walk stalls when a new conflict finds
// a result waiting at the output register. The input is not ready while a
// query is running. Configuration is taken at any time.
// ---------------------------------------------------------------------------
module dc_net_blame_parity_matrix_top
	import dcbpm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [CNT_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          mode,
	input  logic [IDX_W-1:0]    index,
	input  logic [VEC_W-1:0]    alibi_bits,
	input  logic                output_bit,
	input  logic [SLOT_W-1:0]   slot,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          kind,
	output logic [VEC_W-1:0]    bad_mask,
	output logic [SLOT_W-1:0]   conflict_slot,
	output logic [IDX_W-1:0]    user_index,
	output logic [IDX_W-1:0]    server_index,
	output logic                user_claim,
	output logic                server_claim,
	output logic                last
);

	`include "assert_macros.svh"

	logic [VEC_W-1:0]  rows_q [MAX_USERS];
	logic [VEC_W-1:0]  cols_q [MAX_SERVERS];
	logic [VEC_W-1:0]  uout_q, sout_q;
	logic [CNT_W-1:0]  nu_q, ns_q;

	state_e            state_q;
	logic              users_q;
	logic [IDX_W-1:0]  r_q, s_q;
	logic [VEC_W-1:0]  mask_q;
	logic [SLOT_W-1:0] slot_q;
	logic              pend_valid_q;
	logic [IDX_W-1:0]  pend_u_q, pend_s_q;
	logic              pend_uc_q;

	logic              out_valid_q;
	result_t           out_q;

	logic [CNT_W-1:0]  nu, ns;
	logic              in_xfer, out_free;
	logic [IDX_W-1:0]  col_idx;
	logic [VEC_W-1:0]  row_word, col_word, par_word;
	logic [CNT_W-1:0]  inner_n, outer_n;
	logic              par_bit, par_obit, par_bad;
	logic              cell_uc, cell_sc, cell_diff, scan_stall;
	logic              s_last, r_last;
	logic              r_in_range, s_in_range;
	logic              emit_en;
	result_t           emit_res;

	assign nu        = clamp_count(nu_q);
	assign ns        = clamp_count(ns_q);
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// shared read ports of the claim stores
	assign col_idx  = (state_q == ST_SCAN) ? s_q : r_q;
	assign row_word = rows_q[r_q];
	assign col_word = cols_q[col_idx];

	// parity unit
	assign par_word = users_q ? row_word : col_word;
	assign inner_n  = users_q ? ns : nu;
	assign outer_n  = users_q ? nu : ns;
	assign par_bit  = ^(par_word & count_mask(inner_n));
	assign par_obit = users_q ? uout_q[r_q] : sout_q[r_q];
	assign par_bad  = (CNT_W'(r_q) < outer_n) && (par_bit != par_obit);

	// conflict cell compare
	assign cell_uc    = row_word[s_q];
	assign cell_sc    = col_word[r_q];
	assign cell_diff  = cell_uc != cell_sc;
	assign scan_stall = cell_diff && pend_valid_q && !out_free;
	assign s_last     = (CNT_W'(s_q) + CNT_W'(1)) >= ns;
	assign r_last     = (CNT_W'(r_q) + CNT_W'(1)) >= nu;
	assign r_in_range = CNT_W'(r_q) < nu;
	assign s_in_range = CNT_W'(s_q) < ns;

	always_comb begin
		emit_en  = 1'b0;
		emit_res = '0;
		unique case (state_q)
			ST_MASK: begin
				emit_en           = out_free;
				emit_res.kind     = users_q ? KIND_USER_MASK : KIND_SERVER_MASK;
				emit_res.bad_mask = mask_q;
				emit_res.last     = 1'b1;
			end
			ST_SCAN: begin
				emit_en                = cell_diff && pend_valid_q && out_free;
				emit_res.kind          = KIND_CONFLICT;
				emit_res.conflict_slot = slot_q;
				emit_res.user_index    = pend_u_q;
				emit_res.server_index  = pend_s_q;
				emit_res.user_claim    = pend_uc_q;
				emit_res.server_claim  = !pend_uc_q;
			end
			ST_FLUSH: begin
				emit_en                = out_free;
				emit_res.conflict_slot = slot_q;
				emit_res.last          = 1'b1;
				if (pend_valid_q) begin
					emit_res.kind         = KIND_CONFLICT;
					emit_res.user_index   = pend_u_q;
					emit_res.server_index = pend_s_q;
					emit_res.user_claim   = pend_uc_q;
					emit_res.server_claim = !pend_uc_q;
				end else begin
					emit_res.kind = KIND_NONE;
				end
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nu_q <= CNT_MAX;
			ns_q <= CNT_MAX;
		end else if (cfg_valid) begin
			unique case (cfg_idx_e'(cfg_index))
				CFG_USERS:   nu_q <= cfg_data;
				CFG_SERVERS: ns_q <= cfg_data;
				default:     nu_q <= nu_q;
			endcase
		end
	end

	// claim stores and published bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_USERS; i++) begin
				rows_q[i] <= '0;
			end
			for (int i = 0; i < MAX_SERVERS; i++) begin
				cols_q[i] <= '0;
			end
			uout_q <= '0;
			sout_q <= '0;
		end else if (in_xfer) begin
			unique case (mode_e'(mode))
				MODE_USER_ROW: begin
					if (CNT_W'(index) < nu) rows_q[index] <= alibi_bits;
				end
				MODE_SERVER_COL: begin
					if (CNT_W'(index) < ns) cols_q[index] <= alibi_bits;
				end
				MODE_USER_OUT: begin
					if (CNT_W'(index) < nu) uout_q[index] <= output_bit;
				end
				MODE_SERVER_OUT: begin
					if (CNT_W'(index) < ns) sout_q[index] <= output_bit;
				end
				default: begin
					uout_q <= uout_q;
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			users_q      <= 1'b0;
			r_q          <= '0;
			s_q          <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						r_q          <= '0;
						s_q          <= '0;
						pend_valid_q <= 1'b0;
						unique case (mode_e'(mode))
							MODE_BAD_USERS: begin
								users_q <= 1'b1;
								state_q <= ST_PAR;
							end
							MODE_BAD_SERVERS: begin
								users_q <= 1'b0;
								state_q <= ST_PAR;
							end
							MODE_CONFLICTS: begin
								state_q <= ((nu == '0) || (ns == '0)) ? ST_FLUSH : ST_SCAN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PAR: begin
					r_q <= r_q + IDX_W'(1);
					if (r_q == IDX_W'(MAX_USERS - 1)) state_q <= ST_MASK;
				end
				ST_MASK: begin
					if (out_free) state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (!scan_stall) begin
						if (cell_diff) begin
							pend_valid_q <= 1'b1;
						end
						if (s_last) begin
							s_q <= '0;
							if (r_last) begin
								state_q <= ST_FLUSH;
							end else begin
								r_q <= r_q + IDX_W'(1);
							end
						end else begin
							s_q <= s_q + IDX_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			slot_q <= slot;
			mask_q <= '0;
		end else if (state_q == ST_PAR) begin
			mask_q[r_q] <= par_bad;
		end
		if ((state_q == ST_SCAN) && cell_diff && !scan_stall) begin
			pend_u_q  <= r_q;
			pend_s_q  <= s_q;
			pend_uc_q <= cell_uc;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) out_q <= emit_res;
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_q.kind;
	assign bad_mask      = out_q.bad_mask;
	assign conflict_slot = out_q.conflict_slot;
	assign user_index    = out_q.user_index;
	assign server_index  = out_q.server_index;
	assign user_claim    = out_q.user_claim;
	assign server_claim  = out_q.server_claim;
	assign last          = out_q.last;

	`DCBPM_ASSERT(a_pend_idle, clk, arst_n, (state_q == ST_IDLE) |-> !pend_valid_q, "pending conflict left in idle")
	`DCBPM_ASSERT(a_scan_range, clk, arst_n, (state_q == ST_SCAN) |-> (r_in_range && s_in_range), "scan cell outside counts")
	`DCBPM_ASSERT(a_conflict_claims, clk, arst_n, (out_valid && (kind == KIND_CONFLICT)) |-> (user_claim != server_claim), "conflict with equal claims")
	`DCBPM_ASSERT_NEXT(a_emit_no_drop, clk, arst_n, emit_en, out_valid_q, "result dropped at output register")

endmodule

@@ tb/sv/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the blame parity matrix.
// ---------------------------------------------------------------------------
// Items are queued by the stimulus process and sent by a clocked driver. At
// each accepted transfer the driver updates a local copy of the claim matrix
// and queues the answers that item must produce. A clocked monitor compares
// every output transfer field by field with the oldest queued answer. The run
// steps through several user/server counts, including zero and counts above
// the matrix size, and several handshake profiles. One phase holds the output
// off for a long stretch so the input backs up.
// ---------------------------------------------------------------------------
module tb;
	import dcbpm_pkg::*;

	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASES      = 7;
	localparam int LOAD_SETTLE = 20;

	typedef struct packed {
		logic [2:0]        mode;
		logic [IDX_W-1:0]  index;
		logic [VEC_W-1:0]  alibi_bits;
		logic              output_bit;
		logic [SLOT_W-1:0] slot;
	} matrix_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [0:0]        cfg_index = CFG_USERS;
	logic [CNT_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	matrix_item_t      cur_item = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        kind;
	logic [VEC_W-1:0]  bad_mask;
	logic [SLOT_W-1:0] conflict_slot;
	logic [IDX_W-1:0]  user_index;
	logic [IDX_W-1:0]  server_index;
	logic              user_claim;
	logic              server_claim;
	logic              last;

	// local copy of the block's state
	logic [VEC_W-1:0] user_rows [MAX_USERS] = '{default: '0};
	logic [VEC_W-1:0] server_cols [MAX_SERVERS] = '{default: '0};
	logic [VEC_W-1:0] user_out = '0;
	logic [VEC_W-1:0] server_out = '0;
	logic [CNT_W-1:0] users_cnt = CNT_MAX;
	logic [CNT_W-1:0] servers_cnt = CNT_MAX;

	matrix_item_t items_to_send [$];
	result_t      answers_due [$];

	int items_queued = 0;
	int live_items_queued = 0;
	int items_accepted = 0;
	int answers_seen = 0;
	int cfg_writes = 0;
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asked = 0;
	int hold_given = 0;
	int hold_left = 0;
	bit run_done = 1'b0;

	int user_plan [PHASES]   = '{8, 1, 0, 15, 5, 8, 3};
	int server_plan [PHASES] = '{8, 1, 8, 3, 0, 12, 6};

	dc_net_blame_parity_matrix_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (cur_item.mode),
		.index        (cur_item.index),
		.alibi_bits   (cur_item.alibi_bits),
		.output_bit   (cur_item.output_bit),
		.slot         (cur_item.slot),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.bad_mask     (bad_mask),
		.conflict_slot(conflict_slot),
		.user_index   (user_index),
		.server_index (server_index),
		.user_claim   (user_claim),
		.server_claim (server_claim),
		.last         (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int users_active();
		return (users_cnt > MAX_USERS) ? MAX_USERS : int'(users_cnt);
	endfunction

	function automatic int servers_active();
		return (servers_cnt > MAX_SERVERS) ? MAX_SERVERS : int'(servers_cnt);
	endfunction

	function automatic logic [VEC_W-1:0] lanes_below(input int n);
		return (n >= VEC_W) ? '1 : VEC_W'((1 << n) - 1);
	endfunction

	// Apply one accepted item to the local state and queue its answers.
	function automatic void predict_matrix_answers(input matrix_item_t it);
		int nu;
		int ns;
		logic [VEC_W-1:0] flags;
		result_t r;
		bit found;
		nu = users_active();
		ns = servers_active();
		flags = '0;
		found = 1'b0;
		case (it.mode)
			MODE_USER_ROW: begin
				if (it.index < nu) user_rows[it.index] = it.alibi_bits;
			end
			MODE_SERVER_COL: begin
				if (it.index < ns) server_cols[it.index] = it.alibi_bits;
			end
			MODE_USER_OUT: begin
				if (it.index < nu) user_out[it.index] = it.output_bit;
			end
			MODE_SERVER_OUT: begin
				if (it.index < ns) server_out[it.index] = it.output_bit;
			end
			MODE_BAD_USERS, MODE_BAD_SERVERS: begin
				r = '0;
				if (it.mode == MODE_BAD_USERS) begin
					for (int u = 0; u < nu; u++)
						flags[u] = (^(user_rows[u] & lanes_below(ns))) ^ user_out[u];
					r.kind = KIND_USER_MASK;
				end else begin
					for (int s = 0; s < ns; s++)
						flags[s] = (^(server_cols[s] & lanes_below(nu))) ^ server_out[s];
					r.kind = KIND_SERVER_MASK;
				end
				r.bad_mask = flags;
				r.last = 1'b1;
				answers_due.push_back(r);
			end
			MODE_CONFLICTS: begin
				for (int u = 0; u < nu; u++) begin
					for (int s = 0; s < ns; s++) begin
						if (user_rows[u][s] != server_cols[s][u]) begin
							r = '0;
							r.kind = KIND_CONFLICT;
							r.conflict_slot = it.slot;
							r.user_index = IDX_W'(u);
							r.server_index = IDX_W'(s);
							r.user_claim = user_rows[u][s];
							r.server_claim = server_cols[s][u];
							answers_due.push_back(r);
							found = 1'b1;
						end
					end
				end
				if (found) begin
					answers_due[answers_due.size() - 1].last = 1'b1;
				end else begin
					r = '0;
					r.kind = KIND_NONE;
					r.conflict_slot = it.slot;
					r.last = 1'b1;
					answers_due.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic queue_item(input logic [2:0] m, input int idx, input int alibi,
			input int obit, input int slot_no);
		matrix_item_t it;
		it.mode = m;
		it.index = IDX_W'(idx);
		it.alibi_bits = VEC_W'(alibi);
		it.output_bit = obit[0];
		it.slot = SLOT_W'(slot_no);
		items_to_send.push_back(it);
		items_queued++;
		// ignored loads and the unused mode do not count as traffic
		if (m == MODE_BAD_USERS || m == MODE_BAD_SERVERS || m == MODE_CONFLICTS)
			live_items_queued++;
		else if ((m == MODE_USER_ROW || m == MODE_USER_OUT) && idx < users_active())
			live_items_queued++;
		else if ((m == MODE_SERVER_COL || m == MODE_SERVER_OUT) && idx < servers_active())
			live_items_queued++;
	endtask

	task automatic queue_loose_item();
		int pick;
		logic [2:0] m;
		pick = $urandom_range(99);
		if (pick < 50) m = 3'($urandom_range(3));
		else if (pick < 63) m = MODE_BAD_USERS;
		else if (pick < 76) m = MODE_BAD_SERVERS;
		else if (pick < 90) m = MODE_CONFLICTS;
		else if (pick < 95) m = MODE_UNUSED;
		else m = 3'($urandom_range(7));
		queue_item(m, $urandom_range(7), $urandom_range(255), $urandom_range(1),
			$urandom_range(65535));
	endtask

	// Rows and columns that agree, up to three cells broken, output bits mostly
	// matching the parity, then all three queries.
	task automatic queue_agreeing_matrix();
		logic [VEC_W-1:0] grid [MAX_USERS];
		logic [VEC_W-1:0] column;
		int flips;
		int r;
		for (int u = 0; u < MAX_USERS; u++) grid[u] = VEC_W'($urandom_range(255));
		for (int u = 0; u < MAX_USERS; u++)
			queue_item(MODE_USER_ROW, u, grid[u], 0, 0);
		for (int s = 0; s < MAX_SERVERS; s++) begin
			for (int u = 0; u < MAX_USERS; u++) column[u] = grid[u][s];
			queue_item(MODE_SERVER_COL, s, column, 0, 0);
		end
		flips = $urandom_range(1) ? 0 : $urandom_range(3, 1);
		for (int f = 0; f < flips; f++) begin
			r = $urandom_range(MAX_USERS - 1);
			grid[r][$urandom_range(MAX_SERVERS - 1)] ^= 1'b1;
			queue_item(MODE_USER_ROW, r, grid[r], 0, 0);
		end
		for (int u = 0; u < MAX_USERS; u++)
			queue_item(MODE_USER_OUT, u, 0,
				(^(grid[u] & lanes_below(servers_active()))) ^ ($urandom_range(7) == 0), 0);
		for (int s = 0; s < MAX_SERVERS; s++) begin
			for (int u = 0; u < MAX_USERS; u++) column[u] = grid[u][s];
			queue_item(MODE_SERVER_OUT, s, 0,
				(^(column & lanes_below(users_active()))) ^ ($urandom_range(7) == 0), 0);
		end
		queue_item(MODE_BAD_USERS, 0, 0, 0, 0);
		queue_item(MODE_BAD_SERVERS, 0, 0, 0, 0);
		queue_item(MODE_CONFLICTS, $urandom_range(7), $urandom_range(255), $urandom_range(1),
			$urandom_range(65535));
	endtask

	task automatic queue_directed();
		queue_item(MODE_CONFLICTS, 0, 0, 0, 16'hFFFF);
		queue_item(MODE_BAD_USERS, 7, 8'hFF, 1, 16'hFFFF);
		queue_item(MODE_BAD_SERVERS, 0, 0, 0, 0);
		queue_item(MODE_USER_ROW, 0, 8'hFF, 0, 0);
		queue_item(MODE_USER_ROW, 7, 8'h80, 1, 16'hFFFF);
		queue_item(MODE_SERVER_COL, 7, 8'hFF, 0, 0);
		queue_item(MODE_SERVER_COL, 0, 8'h01, 0, 0);
		queue_item(MODE_USER_OUT, 7, 0, 1, 0);
		queue_item(MODE_SERVER_OUT, 0, 8'hFF, 1, 0);
		queue_item(MODE_UNUSED, 5, 8'hAA, 1, 16'h1234);
		queue_item(MODE_BAD_USERS, 0, 0, 0, 0);
		queue_item(MODE_BAD_SERVERS, 0, 0, 0, 0);
		queue_item(MODE_CONFLICTS, 0, 0, 0, 0);
		queue_item(MODE_USER_OUT, 7, 0, 0, 0);
		queue_item(MODE_SERVER_OUT, 7, 0, 1, 0);
		queue_item(MODE_BAD_USERS, 0, 0, 0, 0);
		queue_item(MODE_BAD_SERVERS, 0, 0, 0, 0);
		queue_item(MODE_CONFLICTS, 3, 8'h55, 1, 16'h8000);
	endtask

	task automatic write_count(input cfg_idx_e which, input int value);
		cfg_index <= which;
		cfg_data <= CNT_W'(value);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (which == CFG_USERS) users_cnt = CNT_W'(value);
		else servers_cnt = CNT_W'(value);
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_until_drained();
		while (items_accepted != items_queued || answers_due.size() != 0) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		matrix_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_matrix_answers(cur_item);
				items_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (items_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = items_to_send.pop_front();
					cur_item <= nxt;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus a long hold when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_asked != hold_given) begin
			hold_given++;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_field(input string field, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("result %0d: %s expected %0h got %0h", answers_seen, field, want, got);
		end
	endtask

	// monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result %0d: unexpected transfer, kind %0h", answers_seen, kind);
			end else begin
				want = answers_due.pop_front();
				check_field("kind", kind, want.kind);
				check_field("bad_mask", bad_mask, want.bad_mask);
				check_field("conflict_slot", conflict_slot, want.conflict_slot);
				check_field("user_index", user_index, want.user_index);
				check_field("server_index", server_index, want.server_index);
				check_field("user_claim", user_claim, want.user_claim);
				check_field("server_claim", server_claim, want.server_claim);
				check_field("last", last, want.last);
			end
			answers_seen++;
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (!run_done && quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		if (!run_done) begin
			$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus and phase control
	initial begin
		int target;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < PHASES; ph++) begin
			write_count(CFG_USERS, user_plan[ph]);
			write_count(CFG_SERVERS, server_plan[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 66; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 66; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			if (ph == 0) queue_directed();
			if (ph == 5) begin
				hold_asked++;
				queue_item(MODE_CONFLICTS, 0, 0, 0, $urandom_range(65535));
			end
			target = items_queued + 65;
			while (items_queued < target) begin
				if ($urandom_range(99) < 5) queue_agreeing_matrix();
				else queue_loose_item();
			end
			wait_until_drained();
			// a trailing load may still be in flight
			repeat (LOAD_SETTLE) @(posedge clk);
		end
		repeat (100) @(posedge clk);
		run_done = 1'b1;
		$display("Sent %0d items (%0d live) over %0d count settings, %0d register writes.",
			items_accepted, live_items_queued, PHASES, cfg_writes);
		$display("Checked %0d results under four handshake profiles and one long output hold.",
			answers_seen);
		if (mismatch_count == 0 && answers_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count, answers_due.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
